>>> rtl/xbd_pkg.sv
// shared types, constants and helpers for the xorshift dice generator
package xbd_pkg;

    localparam logic [63:0] SEED_SUBST = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MULT   = 64'h2545_F491_4F6C_DD1D;
    localparam int unsigned SHIFT_A    = 12;
    localparam int unsigned SHIFT_B    = 25;
    localparam int unsigned SHIFT_C    = 27;

    localparam logic [2:0] REQ_SEED  = 3'd0;
    localparam logic [2:0] REQ_RAW   = 3'd1;
    localparam logic [2:0] REQ_BELOW = 3'd2;
    localparam logic [2:0] REQ_RANGE = 3'd3;
    localparam logic [2:0] REQ_DIE   = 3'd4;
    localparam logic [2:0] REQ_ROLL  = 3'd5;
    localparam logic [2:0] REQ_KEEP  = 3'd6;

    // start strobes toward the serial arithmetic unit
    typedef struct packed {
        logic mul;
        logic div;
    } xbd_cmd_t;

    // one xorshift state update
    function automatic logic [63:0] xs_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> SHIFT_A);
        t = t ^ (t << SHIFT_B);
        t = t ^ (t >> SHIFT_C);
        return t;
    endfunction

endpackage

>>> rtl/xbd_req_if.sv
// request channel of the dice generator
interface xbd_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [63:0]        seed_value;
    logic [31:0]        limit;
    logic [31:0]        low_bound;
    logic [31:0]        high_bound;
    logic [7:0]         dice_count;
    logic [7:0]         keep_count;
    logic signed [31:0] bonus;

    modport source (output valid, req_type, seed_value, limit, low_bound, high_bound,
                    dice_count, keep_count, bonus, input ready);
    modport sink (input valid, req_type, seed_value, limit, low_bound, high_bound,
                  dice_count, keep_count, bonus, output ready);
endinterface

>>> rtl/xbd_rsp_if.sv
// response channel of the dice generator
interface xbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_word;
    logic [31:0] number;
    logic [63:0] state_now;
    logic        count_error;

    modport source (output valid, random_word, number, state_now, count_error,
                    input ready);
    modport sink (input valid, random_word, number, state_now, count_error,
                  output ready);
endinterface

>>> rtl/xbd_ram.sv
// generic single-write single-read ram with registered read
module xbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/xbd_arith.sv
// bit-serial 64x64 multiplier by the mix constant and 64/32 remainder unit
module xbd_arith import xbd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  xbd_cmd_t    cmd,
    input  logic [63:0] a_op,
    input  logic [31:0] d_op,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mode_reg, mode_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mc_reg, mc_next;
    logic [63:0] sh_reg, sh_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        rem_sh    = {rem_reg[31:0], sh_reg[63]};
        if (cmd.mul || cmd.div)
        begin
            busy_next = 1'b1;
            mode_next = cmd.mul;
            cnt_next  = '0;
            acc_next  = '0;
            mc_next   = MIX_MULT;
            sh_next   = a_op;
            rem_next  = '0;
            d_next    = d_op;
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                if (sh_reg[0])
                begin
                    acc_next = acc_reg + mc_reg;
                end
                mc_next = {mc_reg[62:0], 1'b0};
                sh_next = {1'b0, sh_reg[63:1]};
            end
            else
            begin
                rem_next = (rem_sh >= {1'b0, d_reg}) ? rem_sh - {1'b0, d_reg} : rem_sh;
                sh_next  = {sh_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done   = done_reg;
    assign result = mode_reg ? acc_reg : {32'd0, rem_reg[31:0]};

endmodule

>>> rtl/xbd_top.sv
// top level of the xorshift64* dice generator with rejection sampling
// work: seed loads the state; raw word takes one multiply; each drawn value takes
// a multiply and a remainder plus a multiply per rejected generator word, and at most
// one remainder per request forms the rejection cut; keep best rescans all dice per kept die
// throughput: one request at a time, set by the bit-serial multiply/remainder unit
// reset: asynchronous active low, generator state returns to the substitute seed
module xorshift_bounded_dice_generator_top import xbd_pkg::*; #(
    parameter int MAX_DICE = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    xbd_req_if.sink   req,
    xbd_rsp_if.source rsp
);

    localparam int IDX_W = (MAX_DICE > 1) ? $clog2(MAX_DICE) : 1;
    localparam int CNT_W = $clog2(MAX_DICE + 1);
    localparam logic [7:0] MAX_CNT = 8'(MAX_DICE);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_CUT  = 4'd2;
    localparam logic [3:0] S_LOOP = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_MOD  = 4'd5;
    localparam logic [3:0] S_DIE  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_PICK = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [63:0]         gen_reg, gen_next;
    logic [2:0]          type_reg, type_next;
    logic [31:0]         n_reg, n_next;
    logic [31:0]         off_reg, off_next;
    logic                dice_reg, dice_next;
    logic                kmode_reg, kmode_next;
    logic [31:0]         total_reg, total_next;
    logic [63:0]         word_reg, word_next;
    logic                err_reg, err_next;
    logic [63:0]         cut_reg, cut_next;
    logic [31:0]         val_reg, val_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    kleft_reg, kleft_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic [IDX_W-1:0]    bidx_reg, bidx_next;
    logic [31:0]         best_reg, best_next;
    logic                have_reg, have_next;
    logic [MAX_DICE-1:0] used_reg, used_next;
    logic                ovalid_reg, ovalid_next;
    logic [63:0]         oword_reg, oword_next;
    logic [31:0]         onum_reg, onum_next;
    logic [63:0]         ostate_reg, ostate_next;
    logic                oerr_reg, oerr_next;

    xbd_cmd_t    cmd;
    logic [63:0] a_op;
    logic [31:0] d_op;
    logic        ar_done;
    logic [63:0] ar_result;
    logic        ram_we;
    logic [31:0] ram_rdata;
    logic [63:0] gen_step;

    assign gen_step = xs_step(gen_reg);

    // shared serial multiply and remainder
    xbd_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a_op   (a_op),
        .d_op   (d_op),
        .done   (ar_done),
        .result (ar_result)
    );

    // dice of a keep best request
    xbd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DICE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (val_reg),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        gen_next    = gen_reg;
        type_next   = type_reg;
        n_next      = n_reg;
        off_next    = off_reg;
        dice_next   = dice_reg;
        kmode_next  = kmode_reg;
        total_next  = total_reg;
        word_next   = word_reg;
        err_next    = err_reg;
        cut_next    = cut_reg;
        val_next    = val_reg;
        left_next   = left_reg;
        cnt_next    = cnt_reg;
        kleft_next  = kleft_reg;
        idx_next    = idx_reg;
        scan_next   = scan_reg;
        bidx_next   = bidx_reg;
        best_next   = best_reg;
        have_next   = have_reg;
        used_next   = used_reg;
        ovalid_next = ovalid_reg;
        oword_next  = oword_reg;
        onum_next   = onum_reg;
        ostate_next = ostate_reg;
        oerr_next   = oerr_reg;
        cmd         = '0;
        a_op        = gen_step;
        d_op        = n_reg;
        ram_we      = 1'b0;

        // output register drains independently of the sequencer
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    total_next = '0;
                    word_next  = '0;
                    err_next   = 1'b0;
                    kmode_next = 1'b0;
                    idx_next   = '0;
                    used_next  = '0;
                    left_next  = CNT_W'(1);
                    n_next     = req.limit;
                    off_next   = 32'd1;
                    dice_next  = 1'b1;
                    state_next = S_PREP;
                    unique case (req.req_type)
                        REQ_SEED:
                        begin
                            gen_next   = (req.seed_value == 64'd0) ? SEED_SUBST
                                                                   : req.seed_value;
                            state_next = S_DONE;
                        end
                        REQ_RAW:
                        begin
                            gen_next   = gen_step;
                            cmd.mul    = 1'b1;
                            state_next = S_MUL;
                        end
                        REQ_BELOW:
                        begin
                            off_next  = 32'd0;
                            dice_next = 1'b0;
                        end
                        REQ_RANGE:
                        begin
                            if (req.high_bound <= req.low_bound)
                            begin
                                total_next = req.low_bound;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                n_next    = req.high_bound - req.low_bound + 32'd1;
                                off_next  = req.low_bound;
                                dice_next = 1'b0;
                            end
                        end
                        REQ_DIE:
                        begin
                        end
                        REQ_ROLL:
                        begin
                            if (req.dice_count > MAX_CNT)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                left_next  = CNT_W'(req.dice_count);
                                total_next = req.bonus;
                            end
                        end
                        REQ_KEEP:
                        begin
                            if (req.dice_count > MAX_CNT || req.keep_count > MAX_CNT)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else if (req.dice_count == 8'd0 || req.keep_count == 8'd0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                left_next  = CNT_W'(req.dice_count);
                                cnt_next   = CNT_W'(req.dice_count);
                                kleft_next = CNT_W'(req.keep_count);
                                kmode_next = (req.keep_count < req.dice_count);
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PREP:
            begin
                // rejection cut only matters when a draw happens
                if (n_reg > 32'd1 && left_reg != '0)
                begin
                    a_op       = '1;
                    cmd.div    = 1'b1;
                    state_next = S_CUT;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_CUT:
            begin
                if (ar_done)
                begin
                    cut_next   = ~64'd0 - ar_result;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (left_reg == '0)
                begin
                    scan_next  = '0;
                    have_next  = 1'b0;
                    state_next = kmode_reg ? S_RD : S_DONE;
                end
                else if (n_reg < 32'd2)
                begin
                    val_next   = dice_reg ? n_reg : off_reg;
                    state_next = S_DIE;
                end
                else
                begin
                    gen_next   = gen_step;
                    cmd.mul    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (ar_done)
                begin
                    if (type_reg == REQ_RAW)
                    begin
                        word_next  = ar_result;
                        state_next = S_DONE;
                    end
                    else if (ar_result >= cut_reg)
                    begin
                        // rejected word, draw again
                        gen_next = gen_step;
                        cmd.mul  = 1'b1;
                    end
                    else
                    begin
                        a_op       = ar_result;
                        cmd.div    = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (ar_done)
                begin
                    val_next   = ar_result[31:0] + off_reg;
                    state_next = S_DIE;
                end
            end
            S_DIE:
            begin
                if (kmode_reg)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    total_next = total_reg + val_reg;
                end
                left_next  = left_reg - CNT_W'(1);
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_LOOP;
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!used_reg[scan_reg]
                    && (!have_reg || $signed(ram_rdata) > $signed(best_reg)))
                begin
                    best_next = ram_rdata;
                    bidx_next = scan_reg;
                    have_next = 1'b1;
                end
                if (CNT_W'(scan_reg) + CNT_W'(1) == cnt_reg)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    scan_next  = scan_reg + IDX_W'(1);
                    state_next = S_RD;
                end
            end
            S_PICK:
            begin
                total_next          = total_reg + best_reg;
                used_next[bidx_reg] = 1'b1;
                kleft_next          = kleft_reg - CNT_W'(1);
                scan_next           = '0;
                have_next           = 1'b0;
                state_next          = (kleft_reg == CNT_W'(1)) ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = word_reg;
                    onum_next   = err_reg ? 32'd0 : total_reg;
                    ostate_next = gen_reg;
                    oerr_next   = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            gen_reg    <= SEED_SUBST;
            ovalid_reg <= 1'b0;
            used_reg   <= '0;
            have_reg   <= 1'b0;
            kmode_reg  <= 1'b0;
            type_reg   <= REQ_SEED;
            left_reg   <= '0;
            cnt_reg    <= '0;
            kleft_reg  <= '0;
            idx_reg    <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            gen_reg    <= gen_next;
            ovalid_reg <= ovalid_next;
            used_reg   <= used_next;
            have_reg   <= have_next;
            kmode_reg  <= kmode_next;
            type_reg   <= type_next;
            left_reg   <= left_next;
            cnt_reg    <= cnt_next;
            kleft_reg  <= kleft_next;
            idx_reg    <= idx_next;
            scan_reg   <= scan_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        off_reg    <= off_next;
        dice_reg   <= dice_next;
        total_reg  <= total_next;
        word_reg   <= word_next;
        err_reg    <= err_next;
        cut_reg    <= cut_next;
        val_reg    <= val_next;
        bidx_reg   <= bidx_next;
        best_reg   <= best_next;
        oword_reg  <= oword_next;
        onum_reg   <= onum_next;
        ostate_reg <= ostate_next;
        oerr_reg   <= oerr_next;
    end

    assign rsp.valid       = ovalid_reg;
    assign rsp.random_word = oword_reg;
    assign rsp.number      = onum_reg;
    assign rsp.state_now   = ostate_reg;
    assign rsp.count_error = oerr_reg;

endmodule
